[design/video_sync_scanline_generator_unit_defines.svh]
// Assertion macros shared by the scanline generator modules.
`ifndef VIDEO_SYNC_SCANLINE_GENERATOR_UNIT_DEFINES_SVH
`define VIDEO_SYNC_SCANLINE_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VSG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define VSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/vsg_pkg.sv]
// Package with the types, constants and register codes of the scanline generator.
package vsg_pkg;

    localparam int unsigned LINE_BITS_DEF = 10;
    localparam int unsigned CFG_W         = 10;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned TICK_W        = 12;
    localparam int unsigned SCANLINE_W    = 10;

    localparam logic [CFG_W-1:0] VERTICAL_TOTAL_RST   = 10'd524;
    localparam logic [CFG_W-1:0] HORIZONTAL_TOTAL_RST = 10'd857;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTICAL_TOTAL   = 3'd0,
        CFG_HORIZONTAL_TOTAL = 3'd1,
        CFG_CLOCK_DOUBLE     = 3'd2,
        CFG_INTERLACE        = 3'd3,
        CFG_VBLANK_IN_LINE   = 3'd4,
        CFG_VBLANK_OUT_LINE  = 3'd5,
        CFG_VSYNC_START      = 3'd6,
        CFG_VSYNC_END        = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] vertical_total;
        logic [CFG_W-1:0] horizontal_total;
        logic             clock_double;
        logic             interlace;
        logic [CFG_W-1:0] vblank_in_line;
        logic [CFG_W-1:0] vblank_out_line;
        logic [CFG_W-1:0] vsync_start;
        logic [CFG_W-1:0] vsync_end;
    } t_cfg;

    typedef struct packed {
        logic                  line_end;
        logic                  vblank_in;
        logic                  vblank_out;
        logic                  vsync;
        logic [SCANLINE_W-1:0] scanline;
    } t_result;

endpackage

[design/vsg_cfg.sv]
// Configuration register file with the counter restart strobe.
module vsg_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [vsg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vsg_pkg::CFG_W-1:0]     i_cfg_data,
    output vsg_pkg::t_cfg                 o_cfg,
    output logic                          o_restart
);

    vsg_pkg::t_cfg r_cfg;
    vsg_pkg::t_cfg n_cfg;
    logic          n_restart;

    always_comb begin
        n_cfg     = r_cfg;
        n_restart = 1'b0;
        if (i_cfg_wr_en) begin
            n_restart = 1'b1;
            case (vsg_pkg::t_cfg_idx'(i_cfg_index))
                vsg_pkg::CFG_VERTICAL_TOTAL:   n_cfg.vertical_total   = i_cfg_data;
                vsg_pkg::CFG_HORIZONTAL_TOTAL: n_cfg.horizontal_total = i_cfg_data;
                vsg_pkg::CFG_CLOCK_DOUBLE:     n_cfg.clock_double     = i_cfg_data[0];
                vsg_pkg::CFG_INTERLACE:        n_cfg.interlace        = i_cfg_data[0];
                vsg_pkg::CFG_VBLANK_IN_LINE:   n_cfg.vblank_in_line   = i_cfg_data;
                vsg_pkg::CFG_VBLANK_OUT_LINE:  n_cfg.vblank_out_line  = i_cfg_data;
                vsg_pkg::CFG_VSYNC_START:      n_cfg.vsync_start      = i_cfg_data;
                vsg_pkg::CFG_VSYNC_END:        n_cfg.vsync_end        = i_cfg_data;
                default:                       n_restart              = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vertical_total   <= vsg_pkg::VERTICAL_TOTAL_RST;
            r_cfg.horizontal_total <= vsg_pkg::HORIZONTAL_TOTAL_RST;
            r_cfg.clock_double     <= 1'b0;
            r_cfg.interlace        <= 1'b0;
            r_cfg.vblank_in_line   <= '0;
            r_cfg.vblank_out_line  <= '0;
            r_cfg.vsync_start      <= '0;
            r_cfg.vsync_end        <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg     = r_cfg;
    assign o_restart = n_restart;

endmodule

[design/vsg_core.sv]
// Tick and scanline counters with the per-item line end and sync decode.
`include "video_sync_scanline_generator_unit_defines.svh"

module vsg_core #(
    parameter int unsigned LINE_BITS = vsg_pkg::LINE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vsg_pkg::t_cfg    i_cfg,
    input  logic             i_restart,
    input  logic             i_fire,
    input  logic             i_advance,
    output vsg_pkg::t_result o_result
);

    localparam int unsigned CMP_W    = (LINE_BITS > vsg_pkg::CFG_W) ? LINE_BITS : vsg_pkg::CFG_W;
    localparam int unsigned HP1_W    = vsg_pkg::CFG_W + 1;
    localparam int unsigned PERIOD_W = vsg_pkg::TICK_W + 1;

    logic [vsg_pkg::TICK_W-1:0]     r_tick;
    logic [LINE_BITS-1:0]           r_line;
    logic                           r_vsync;
    logic [vsg_pkg::SCANLINE_W-1:0] r_latched_line;

    logic [vsg_pkg::TICK_W-1:0]     n_tick;
    logic [LINE_BITS-1:0]           n_line;

    logic [HP1_W-1:0]    hp1;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] next_tick;
    logic                ended;
    logic [LINE_BITS-1:0] line_cur;
    logic [CMP_W-1:0]    line_x;
    logic [CMP_W-1:0]    start_x;
    logic [CMP_W-1:0]    end_x;
    logic                vs;

    always_comb begin
        hp1 = {1'b0, i_cfg.horizontal_total} + HP1_W'(1);
        case ({i_cfg.clock_double, i_cfg.interlace})
            2'b00:   period = {hp1, 2'b00};
            2'b01:   period = {1'b0, hp1, 1'b0};
            2'b10:   period = {1'b0, hp1, 1'b0};
            default: period = {2'b00, hp1};
        endcase
    end

    assign next_tick = {1'b0, r_tick} + PERIOD_W'(1);
    assign ended     = i_advance && (next_tick >= period);

    assign line_cur = (CMP_W'(r_line) > CMP_W'(i_cfg.vertical_total)) ? '0 : r_line;
    assign line_x   = CMP_W'(line_cur);
    assign start_x  = CMP_W'(i_cfg.vsync_start);
    assign end_x    = CMP_W'(i_cfg.vsync_end);

    always_comb begin
        if (i_cfg.vsync_start < i_cfg.vsync_end) begin
            vs = (line_x >= start_x) && (line_x < end_x);
        end else begin
            vs = (line_x >= start_x) || (line_x < end_x);
        end
    end

    always_comb begin
        o_result.line_end   = ended;
        o_result.vblank_in  = ended && (line_x == CMP_W'(i_cfg.vblank_in_line));
        o_result.vblank_out = ended && (line_x == CMP_W'(i_cfg.vblank_out_line));
        o_result.vsync      = ended ? vs : r_vsync;
        o_result.scanline   = ended ? vsg_pkg::SCANLINE_W'(line_cur) : r_latched_line;
    end

    always_comb begin
        n_tick = r_tick;
        n_line = r_line;
        if (i_fire && i_advance) begin
            if (ended) begin
                n_tick = '0;
                n_line = line_cur + LINE_BITS'(1);
            end else begin
                n_tick = next_tick[vsg_pkg::TICK_W-1:0];
            end
        end
        if (i_restart) begin
            n_tick = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick         <= '0;
            r_line         <= '0;
            r_vsync        <= 1'b0;
            r_latched_line <= '0;
        end else begin
            r_tick <= n_tick;
            r_line <= n_line;
            if (i_fire && ended) begin
                r_vsync        <= vs;
                r_latched_line <= vsg_pkg::SCANLINE_W'(line_cur);
            end
        end
    end

    `VSG_ASSERT_NOW(a_tick_below_period, i_clk, i_rst_n, 1'b1, ({1'b0, r_tick} < period), "Tick counter reached the line period.")
    `VSG_ASSERT_NEXT(a_line_end_clears_tick, i_clk, i_rst_n, i_fire && ended, r_tick == '0, "Tick counter not cleared after a line end.")
    `VSG_ASSERT_NEXT(a_query_keeps_line, i_clk, i_rst_n, i_fire && !i_advance, $stable(r_line), "A status query moved the scanline counter.")

endmodule

[design/video_sync_scanline_generator_unit.sv]
// Video timing sync generator: one base tick per advancing item, line end and sync flags per result.
// The block accepts one item in every clock cycle while o_in_stall is low and returns exactly one
// result for each item: the item is held in an input register, and the tick and scanline
// counters are updated when it leaves that register, while the result register is loaded.
// Throughput is set by the single counter update per cycle and drops only while the result
// register is stalled. A configuration write restarts the tick counter of the current line.
`include "video_sync_scanline_generator_unit_defines.svh"

module video_sync_scanline_generator_unit #(
    parameter int unsigned LINE_BITS = vsg_pkg::LINE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [vsg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vsg_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_advance,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_line_end,
    output logic                           o_hblank_in_irq,
    output logic                           o_vblank_in_irq,
    output logic                           o_vblank_out_irq,
    output logic                           o_vsync_status,
    output logic [vsg_pkg::SCANLINE_W-1:0] o_scanline_status
);

    vsg_pkg::t_cfg    cfg;
    vsg_pkg::t_result result;
    logic             restart;

    logic             r_in_valid;
    logic             r_advance;
    logic             r_out_valid;
    vsg_pkg::t_result r_result;

    logic             out_en;
    logic             fire;
    logic             in_accept;

    assign out_en     = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_en;
    assign o_in_stall = r_in_valid && !out_en;
    assign in_accept  = i_in_valid && !o_in_stall;

    vsg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_restart   (restart)
    );

    vsg_core #(
        .LINE_BITS (LINE_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_restart (restart),
        .i_fire    (fire),
        .i_advance (r_advance),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_en) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_advance <= i_advance;
        end
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_line_end        = r_result.line_end;
    assign o_hblank_in_irq   = r_result.line_end;
    assign o_vblank_in_irq   = r_result.vblank_in;
    assign o_vblank_out_irq  = r_result.vblank_out;
    assign o_vsync_status    = r_result.vsync;
    assign o_scanline_status = r_result.scanline;

    `VSG_ASSERT_NOW(a_irq_needs_line_end, i_clk, i_rst_n, o_out_valid && !o_line_end, !o_vblank_in_irq && !o_vblank_out_irq && !o_hblank_in_irq, "Interrupt pulse without a line end.")
    `VSG_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, fire, o_out_valid, "A processed item produced no result.")
    `VSG_ASSERT_NEXT(a_accept_fills_input, i_clk, i_rst_n, in_accept, r_in_valid, "An accepted item did not reach the input register.")

endmodule
